/* rtl/core/cbfd_pkg.sv */
// Shared constants, types and the prime table for the clause Bloom filter.
// No dependencies; imported by the hash lanes and the top level.
`timescale 1ns / 1ps

package cbfd_pkg;

  // Size of the bit store. It must be a power of two, so the modulo is a mask.
  localparam int FILTER_BITS = 16777216;
  localparam int LANES       = 4;
  localparam int LANE_W      = $clog2(LANES);
  localparam int IDX_W       = $clog2(FILTER_BITS);
  // The bit store is kept as rows of ROW_W bits.
  localparam int ROW_W       = 64;
  localparam int BIT_W       = $clog2(ROW_W);
  localparam int ROW_AW      = IDX_W - BIT_W;
  localparam int ROWS        = FILTER_BITS / ROW_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TEST,
    ST_TEST_END,
    ST_SET_RD,
    ST_SET_WR
  } state_t;

  typedef enum logic {
    OP_WORD  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef struct packed {
    logic upd;  // fold the current literal into all lanes
    logic clr;  // clause finished, zero the accumulators
  } hash_ctl_t;

  function automatic logic [31:0] lane_prime(input logic [3:0] sel);
    logic [31:0] p;
    case (sel)
      4'd0:    p = 32'd2038072819;
      4'd1:    p = 32'd2038073287;
      4'd2:    p = 32'd2038073761;
      4'd3:    p = 32'd2038074317;
      4'd4:    p = 32'd2038072823;
      4'd5:    p = 32'd2038073321;
      4'd6:    p = 32'd2038073767;
      4'd7:    p = 32'd2038074319;
      4'd8:    p = 32'd2038072847;
      4'd9:    p = 32'd2038073341;
      4'd10:   p = 32'd2038073789;
      4'd11:   p = 32'd2038074329;
      4'd12:   p = 32'd2038074751;
      4'd13:   p = 32'd2038075231;
      4'd14:   p = 32'd2038075751;
      4'd15:   p = 32'd2038076267;
      default: p = 32'd2038072819;
    endcase
    return p;
  endfunction

endpackage

/* rtl/core/clause_bloom_filter_dedup_core.sv */
// Top level of the clause Bloom filter: control sequencer around the bit store.
// Depends on cbfd_pkg, cbfd_hash and cbfd_ram.
//
// Usage:
//   An item is transferred on a rising edge with start high and busy low.
//   opcode selects a clause word or a clear of the whole bit store. The first
//   word of a clause is its header; later words are literals, last_word marks
//   the end. Header and literal words that do not end a clause leave busy low,
//   so literals stream back to back.
//   On the last word the four lane indices are tested in the bit store, a
//   64-bit-row RAM with one read and one write port. A probable duplicate
//   pulses done with admitted low at the end of that test pass.
//   A new clause needs four read-modify-write passes more and pulses done with
//   admitted high after the last of them.
//   done is high for exactly one cycle; the receiver cannot stall it.
//   A clear item sweeps all ROWS = 262144 rows of the store one row a cycle,
//   with no result. Reset runs the same sweep before the first transfer.
`timescale 1ns / 1ps

module clause_bloom_filter_dedup_core import cbfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic signed [31:0] word,
  input  logic               last_word,
  output logic               done,
  output logic               admitted
);

  state_t            state, state_next;
  logic [LANE_W-1:0] lane, lane_next;
  logic              expect_hdr, expect_hdr_next;
  logic              all_set, all_set_next;
  logic [ROW_AW-1:0] clr_addr, clr_addr_next;
  logic [BIT_W-1:0]  rd_bit, rd_bit_next;
  logic              done_next;
  logic              admitted_next;

  hash_ctl_t         hctl;
  logic [IDX_W-1:0]  idx;
  logic [ROW_AW-1:0] row;
  logic [BIT_W-1:0]  bit_sel;
  logic              accept;
  logic              hit;

  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ROW_W-1:0]  ram_rdata;

  cbfd_hash u_hash (
    .clk  (clk),
    .rst  (rst),
    .ctl  (hctl),
    .lit  ($unsigned(word)),
    .lane (lane),
    .idx  (idx)
  );

  cbfd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (row),
    .rdata (ram_rdata)
  );

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign row     = idx[IDX_W-1:BIT_W];
  assign bit_sel = idx[BIT_W-1:0];
  assign hit     = ram_rdata[rd_bit];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      lane       <= '0;
      expect_hdr <= 1'b1;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      lane       <= lane_next;
      expect_hdr <= expect_hdr_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    all_set  <= all_set_next;
    rd_bit   <= rd_bit_next;
    admitted <= admitted_next;
  end

  always_comb begin
    state_next      = state;
    lane_next       = lane;
    expect_hdr_next = expect_hdr;
    all_set_next    = all_set;
    clr_addr_next   = clr_addr;
    rd_bit_next     = rd_bit;
    done_next       = 1'b0;
    admitted_next   = admitted;
    hctl            = '0;
    ram_we          = 1'b0;
    ram_waddr       = clr_addr;
    ram_wdata       = '0;
    ram_re          = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_CLEAR) begin
            clr_addr_next = '0;
            state_next    = ST_CLEAR;
          end else begin
            if (expect_hdr) begin
              expect_hdr_next = 1'b0;
            end else begin
              hctl.upd = 1'b1;
            end
            if (last_word) begin
              lane_next    = '0;
              all_set_next = 1'b1;
              state_next   = ST_TEST;
            end
          end
        end
      end

      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ROW_AW'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      // Reads issue one lane per cycle; each response is checked in the cycle after its read.
      ST_TEST: begin
        ram_re      = 1'b1;
        rd_bit_next = bit_sel;
        if (lane != '0) begin
          all_set_next = all_set & hit;
        end
        lane_next = lane + 1'b1;
        if (lane == LANE_W'(LANES - 1)) begin
          state_next = ST_TEST_END;
        end
      end

      ST_TEST_END: begin
        if (all_set && hit) begin
          done_next       = 1'b1;
          admitted_next   = 1'b0;
          hctl.clr        = 1'b1;
          expect_hdr_next = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_SET_RD;
        end
      end

      ST_SET_RD: begin
        ram_re     = 1'b1;
        state_next = ST_SET_WR;
      end

      // Write lands before the next lane's read, so shared rows merge.
      ST_SET_WR: begin
        ram_we    = 1'b1;
        ram_waddr = row;
        ram_wdata = ram_rdata | (ROW_W'(1) << bit_sel);
        lane_next = lane + 1'b1;
        if (lane == LANE_W'(LANES - 1)) begin
          done_next       = 1'b1;
          admitted_next   = 1'b1;
          hctl.clr        = 1'b1;
          expect_hdr_next = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_SET_RD;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_dup_from_test: assert property (@(posedge clk) disable iff (rst)
    done && !admitted |-> $past(state) == ST_TEST_END)
    else $error("duplicate result without a finished test pass");

  a_new_from_set: assert property (@(posedge clk) disable iff (rst)
    done && admitted |-> $past(state) == ST_SET_WR && $past(lane) == LANE_W'(LANES - 1))
    else $error("admit result before all lanes were set");

  a_last_word_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_WORD && last_word |=> busy && !done)
    else $error("clause end did not start the bit-store test");

  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !done && !ram_re)
    else $error("result or read during the clearing sweep");

endmodule

/* rtl/core/cbfd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module cbfd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/cbfd_hash.sv */
// Four hash lanes: per-literal multiply by a selected prime and XOR accumulate.
// Depends on cbfd_pkg.
`timescale 1ns / 1ps

module cbfd_hash import cbfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  hash_ctl_t         ctl,
  input  logic [31:0]       lit,
  input  logic [LANE_W-1:0] lane,
  output logic [IDX_W-1:0]  idx
);

  logic [31:0] acc  [LANES];
  logic [31:0] prod [LANES];

  // Low 32 bits of the product only.
  always_comb begin
    for (int w = 0; w < LANES; w++) begin
      prod[w] = lit * lane_prime(lit[3:0] ^ 4'(w + 1));
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < LANES; w++) begin
      if (rst || ctl.clr) begin
        acc[w] <= '0;
      end else if (ctl.upd) begin
        acc[w] <= acc[w] ^ prod[w];
      end
    end
  end

  // FILTER_BITS is a power of two: the modulo keeps the low bits.
  assign idx = acc[lane][IDX_W-1:0];

endmodule
